>>> src/msu5_pkg.sv
// Shared constants, types and the cell pattern function of the 5x mask upscaler.
package msu5_pkg;

    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int COORD_W        = 10;
    localparam int BLOCK_N        = 5;
    localparam int CELLS_W        = BLOCK_N * BLOCK_N;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

    typedef struct packed {
        logic pad;       // item belongs to the flush row
        logic last_col;  // last column of its row
        logic below;     // incoming pixel, forced empty in the flush row
    } item_flags_t;

    // 5x5 block for one source pixel from its center and four neighbors.
    function automatic logic [CELLS_W-1:0] make_cells(
        input logic c,
        input logic l,
        input logic r,
        input logic u,
        input logic d
    );
        int kol;
        int x;
        int y;
        int val;
        int ax;
        int ay;
        logic paral;
        logic [CELLS_W-1:0] res;
        kol   = int'(l) + int'(r) + int'(u) + int'(d);
        paral = (l && r) || (u && d);
        x     = r ? BLOCK_N : 0;
        y     = d ? BLOCK_N : 0;
        res   = '0;
        for (int dy = 0; dy < BLOCK_N; dy++) begin
            for (int dx = 0; dx < BLOCK_N; dx++) begin
                ax  = (x > dx) ? (x - dx) : (dx - x);
                ay  = (y > dy) ? (y - dy) : (dy - y);
                val = ax + ay;
                if (x == y) begin
                    if (x == BLOCK_N)
                        val = val - 1;
                    else
                        val = val + 1;
                end
                if (val <= 4)
                    res[dy * BLOCK_N + dx] = 1'b1;
            end
        end
        if (c || kol > 2 || (kol == 2 && paral))
            return '1;
        if (kol < 2)
            return '0;
        return res;
    endfunction

endpackage

>>> src/msu5_front.sv
// Front end: accepts pixels, tracks raster position and classifies each item.
module msu5_front #(
    parameter int MAX_WIDTH  = msu5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msu5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              solid,
    input  logic                              frame_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_eff,
    input  logic                              queue_full,
    input  logic                              clear_busy,
    output logic                              push,
    output logic [$clog2(MAX_WIDTH)-1:0]      push_col,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]   push_row,
    output msu5_pkg::item_flags_t             push_flags
);
    import msu5_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WEW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
    logic [WEW:0]   col_plus;
    logic           pad;
    logic           last_col;

    assign in_stall = queue_full || clear_busy;
    assign push     = in_valid && !in_stall;

    // frame_start puts this item at the origin
    assign col      = frame_start ? '0 : col_reg;
    assign row      = frame_start ? '0 : row_reg;
    assign col_plus = (WEW + 1)'(col) + 1'b1;
    assign pad      = row >= height_eff;
    assign last_col = col_plus >= (WEW + 1)'(width_eff);

    assign push_col        = col;
    assign push_row        = row;
    assign push_flags.pad      = pad;
    assign push_flags.last_col = last_col;
    assign push_flags.below    = pad ? 1'b0 : solid;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = pad ? '0 : row + 1'b1;
            end
            else
            begin
                col_next = col + 1'b1;
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> src/msu5_queue.sv
// Short FIFO between the front end and the back end.
module msu5_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = msu5_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    import msu5_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign full       = count_reg == NW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue holds more than its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push lost");

endmodule

>>> src/msu5_back.sv
// Back end: row stores, neighbor fetch with forwarding, cell pattern and output register.
module msu5_back #(
    parameter int MAX_WIDTH  = msu5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msu5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]        head_col,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     head_row,
    input  msu5_pkg::item_flags_t               head_flags,
    output logic                                pop,
    output logic                                clear_busy,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [msu5_pkg::COORD_W-1:0]        block_col,
    output logic [msu5_pkg::COORD_W-1:0]        block_row,
    output logic [msu5_pkg::CELLS_W-1:0]        cells,
    output logic                                frame_done
);
    import msu5_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // row stores; the middle row has two read ports (column and column + 1)
    logic mid_a_mem [MAX_WIDTH];
    logic mid_b_mem [MAX_WIDTH];
    logic old_mem   [MAX_WIDTH];

    logic              clear_busy_reg;
    logic [CW-1:0]     clear_cnt_reg;

    logic              b2_valid_reg;
    logic [CW-1:0]     b2_col_reg;
    logic [RW-1:0]     b2_row_reg;
    item_flags_t       b2_flags_reg;
    logic              mid_c_reg;
    logic              mid_r_reg;
    logic              old_reg;

    logic              fwd_valid_reg;
    logic [CW-1:0]     fwd_col_reg;
    logic              fwd_below_reg;
    logic              fwd_center_reg;
    logic              left_reg;

    logic              out_valid_reg;
    logic [COORD_W-1:0] block_col_reg;
    logic [COORD_W-1:0] block_row_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic              frame_done_reg;

    logic              load;
    logic              b2_emit;
    logic              b2_leave;
    logic [CW-1:0]     rd_r_addr;
    logic [CW:0]       col_plus;
    logic              hit_c;
    logic              hit_r;
    logic              center;
    logic              left;
    logic              right;
    logic              up;
    logic [CELLS_W-1:0] cells_next;
    logic              mem_we;
    logic [CW-1:0]     mem_addr;
    logic              mem_mid_d;
    logic              mem_old_d;

    assign clear_busy = clear_busy_reg;

    assign b2_emit  = b2_row_reg != '0;
    assign b2_leave = b2_valid_reg && (!b2_emit || !out_valid_reg || !out_stall);
    assign load     = head_valid && !clear_busy_reg && (!b2_valid_reg || b2_leave);
    assign pop      = load;
    assign rd_r_addr = head_col + 1'b1;

    // the item leaving at the load edge wrote nothing visible yet: forward it
    assign col_plus = (CW + 1)'(b2_col_reg) + 1'b1;
    assign hit_c    = fwd_valid_reg && (fwd_col_reg == b2_col_reg);
    assign hit_r    = fwd_valid_reg && ((CW + 1)'(fwd_col_reg) == col_plus);

    assign center = hit_c ? fwd_below_reg : mid_c_reg;
    assign left   = (b2_col_reg == '0) ? 1'b0 : left_reg;
    assign right  = (!b2_flags_reg.last_col && col_plus < (CW + 1)'(MAX_WIDTH))
                    ? (hit_r ? fwd_below_reg : mid_r_reg) : 1'b0;
    assign up     = (b2_row_reg >= RW'(2)) ? (hit_c ? fwd_center_reg : old_reg) : 1'b0;

    assign cells_next = make_cells(center, left, right, up, b2_flags_reg.below);

    assign mem_we    = clear_busy_reg || b2_leave;
    assign mem_addr  = clear_busy_reg ? clear_cnt_reg : b2_col_reg;
    assign mem_mid_d = clear_busy_reg ? 1'b0 : b2_flags_reg.below;
    assign mem_old_d = clear_busy_reg ? 1'b0 : center;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mid_a_mem[mem_addr] <= mem_mid_d;
            mid_b_mem[mem_addr] <= mem_mid_d;
            old_mem[mem_addr]   <= mem_old_d;
        end
        if (load)
        begin
            mid_c_reg <= mid_a_mem[head_col];
            mid_r_reg <= mid_b_mem[rd_r_addr];
            old_reg   <= old_mem[head_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b2_col_reg     <= head_col;
            b2_row_reg     <= head_row;
            b2_flags_reg   <= head_flags;
            fwd_col_reg    <= b2_col_reg;
            fwd_below_reg  <= b2_flags_reg.below;
            fwd_center_reg <= center;
        end
        if (b2_leave && b2_emit)
        begin
            block_col_reg  <= COORD_W'(b2_col_reg);
            block_row_reg  <= COORD_W'(RW'(b2_row_reg - 1'b1));
            cells_reg      <= cells_next;
            frame_done_reg <= b2_flags_reg.pad && b2_flags_reg.last_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
            b2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            left_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clear_busy_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == CW'(MAX_WIDTH - 1))
                    clear_busy_reg <= 1'b0;
            end

            if (load)
                b2_valid_reg <= 1'b1;
            else if (b2_leave)
                b2_valid_reg <= 1'b0;

            if (load)
                fwd_valid_reg <= b2_leave;
            else if (b2_leave)
                fwd_valid_reg <= 1'b0;

            if (b2_leave)
                left_reg <= center;

            if (b2_leave && b2_emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_col  = block_col_reg;
    assign block_row  = block_row_reg;
    assign cells      = cells_reg;
    assign frame_done = frame_done_reg;

    a_clear_holds_items: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !b2_valid_reg)
        else $error("item in flight during store clear");

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> b2_valid_reg)
        else $error("forwarding armed without an item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(b2_leave && b2_emit))
        else $error("held result overwritten");

endmodule

>>> src/mask_upscale_5x_smooth_unit.sv
// Top level of the 5x mask upscaler with corner smoothing.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ----------------------------------------
//  input     in         in_valid / in_stall  solid, frame_start
//  output    out        out_valid/out_stall  block_col, block_row, cells, frame_done
//  config    in         cfg_write            cfg_index, cfg_data (no read-back)
//
//  One pixel transfer per cycle sustained while out_stall is low; out_valid rises once the pixel
//  that completes a block's neighborhood has passed the queue write at the transfer edge,
//  the store read and the output register.
//  Blocks of row r come out while row r+1 streams in; a trailing row of pad items
//  flushes the last row and carries frame_done on its last block.
//  After reset both row stores are cleared one column per cycle, in_stall high
//  meanwhile; configuration writes are taken at all times.
//  A stall on the output backs up into the queue, then raises in_stall.
module mask_upscale_5x_smooth_unit #(
    parameter int MAX_WIDTH  = msu5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msu5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [msu5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msu5_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           solid,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [msu5_pkg::COORD_W-1:0]   block_col,
    output logic [msu5_pkg::COORD_W-1:0]   block_row,
    output logic [msu5_pkg::CELLS_W-1:0]   cells,
    output logic                           frame_done
);
    import msu5_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int FW  = $bits(item_flags_t);
    localparam int QW  = CW + RW + FW;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [WEW-1:0]   width_eff;
    logic [RW-1:0]    height_eff;

    logic             queue_full;
    logic             clear_busy;
    logic             push;
    logic [CW-1:0]    push_col;
    logic [RW-1:0]    push_row;
    item_flags_t      push_flags;
    logic             pop;
    logic             head_valid;
    logic [QW-1:0]    head_data;
    logic [CW-1:0]    head_col;
    logic [RW-1:0]    head_row;
    item_flags_t      head_flags;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions in use: clamped to 1..MAX
    always_comb
    begin
        if (image_width_reg == '0)
            width_eff = WEW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            width_eff = WEW'(MAX_WIDTH);
        else
            width_eff = WEW'(image_width_reg);

        if (image_height_reg == '0)
            height_eff = RW'(1);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            height_eff = RW'(MAX_HEIGHT);
        else
            height_eff = RW'(image_height_reg);
    end

    msu5_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .solid       (solid),
        .frame_start (frame_start),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .queue_full  (queue_full),
        .clear_busy  (clear_busy),
        .push        (push),
        .push_col    (push_col),
        .push_row    (push_row),
        .push_flags  (push_flags)
    );

    msu5_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_col, push_row, push_flags}),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_col   = head_data[QW-1 -: CW];
    assign head_row   = head_data[FW +: RW];
    assign head_flags = item_flags_t'(head_data[FW-1:0]);

    msu5_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_col   (head_col),
        .head_row   (head_row),
        .head_flags (head_flags),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_col  (block_col),
        .block_row  (block_row),
        .cells      (cells),
        .frame_done (frame_done)
    );

endmodule
